FILE: rtl/core/assert_macros.svh
// assertion macros shared by the record deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rdc_pkg.sv
// types, constants and the crc function of the record deframer
package rdc_pkg;

    // internal sizing
    localparam int LENGTH_BITS = 20;
    localparam int OFFSET_BITS = 32;

    // fixed field widths
    localparam int WORD_W     = 32;
    localparam int VERSION_W  = 16;
    localparam int MAXLEN_W   = 20;
    localparam int OFFSET_W   = 32;
    localparam int PLEN_W     = 20;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // header field sizes in bytes
    localparam int VERSION_BYTES = 2;
    localparam int WORD_BYTES    = 4;

    // result queue, depth is a power of two
    localparam int Q_DEPTH = 4;

    localparam logic [WORD_W-1:0]    CRC_POLY      = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0]    MAGIC_RESET   = 32'd844322125;
    localparam logic [VERSION_W-1:0] VERSION_RESET = 16'd1;
    localparam logic [MAXLEN_W-1:0]  MAXLEN_RESET  = 20'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN  = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_VERSION,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CRC
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_SHORT_HDR,
        ST_BAD_MAGIC,
        ST_BAD_VERSION,
        ST_BAD_LENGTH,
        ST_SHORT_PAYLOAD,
        ST_MISSING_CRC,
        ST_CRC_MISMATCH
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic                item_kind;
        logic [7:0]          payload_byte;
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] record_offset;
        logic [PLEN_W-1:0]   rec_length;
        logic                last;
    } t_out_item;

    // one queue entry: everything one input byte produces
    typedef struct packed {
        logic                has_pay;
        logic                has_stat;
        logic [7:0]          pay_byte;
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] offset;
        logic [PLEN_W-1:0]   length;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // reflected crc-32, one byte
    function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] crc,
                                                    input logic [7:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {{(WORD_W-8){1'b0}}, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/record_deframer_crc_check.sv
// top level of the length-prefixed record deframer with crc-32 check
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ------------------------------------
//  in        sink       i_in_valid / o_in_stall      i_in_item  (data_byte, end_of_file)
//  out       source     o_out_valid / i_out_stall    o_out_item (kind, byte, status, ...)
//  cfg       sink       i_cfg_wr_en                  i_cfg_index, i_cfg_wdata
//
//  one input byte per cycle while the result queue has room;
//  every byte is parsed in the cycle it is taken, and any results of a byte reach
//  o_out_valid through the queue and the output register; an end-of-file byte that
//  falls inside a payload makes two transactions
//  o_in_stall rises only when the four-entry result queue is full
//  reset is synchronous, active low; it restores the registers to their defaults
//
module record_deframer_crc_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte stream in
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rdc_pkg::t_in_item              i_in_item,
    // results out
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rdc_pkg::t_out_item             o_out_item,
    // register writes
    input  logic                           i_cfg_wr_en,
    input  logic [rdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // front side
    logic              in_accept;
    logic              push;
    rdc_pkg::t_job     push_job;

    // queue to back side
    rdc_pkg::t_job     head_job;
    rdc_pkg::t_q_flags q_flags;
    logic              pop;

    // a byte is taken whenever the queue has room; the front never waits on the output
    assign o_in_stall = q_flags.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    // parser: header compares, crc update, length count and status per byte
    rdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_item      (i_in_item),
        .o_push      (push),
        .o_job       (push_job)
    );

    // each entry holds all results of one byte, so a push never needs two slots
    rdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_flags (q_flags)
    );

    // output register: splits a payload plus status entry into two transactions
    rdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_job),
        .i_flags (q_flags),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

FILE: rtl/core/rdc_front.sv
// parser front end: header checks, crc, record status and configuration registers
module rdc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rdc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_accept,
    input  rdc_pkg::t_in_item                i_item,
    output logic                             o_push,
    output rdc_pkg::t_job                    o_job
);

    `include "assert_macros.svh"

    localparam int LB = rdc_pkg::LENGTH_BITS;
    localparam int OB = rdc_pkg::OFFSET_BITS;
    localparam int WW = rdc_pkg::WORD_W;

    logic [WW-1:0]                   r_magic;
    logic [rdc_pkg::VERSION_W-1:0]   r_version;
    logic [rdc_pkg::MAXLEN_W-1:0]    r_max;

    rdc_pkg::t_phase r_phase, n_phase, phase_step;
    logic            r_halted, n_halted, halt_step;
    logic [LB-1:0]   r_count, n_count, count_step;
    logic [WW-1:0]   r_shift, n_shift, shift_step;
    logic [WW-1:0]   r_crc, n_crc, crc_step;
    logic [LB-1:0]   r_len, n_len, len_step;
    logic [OB-1:0]   r_pos, n_pos;
    logic [OB-1:0]   r_start, n_start, start_step;

    logic            eof;
    logic            first;
    logic [OB-1:0]   cur_start;
    logic [LB-1:0]   cur_len;
    logic [WW-1:0]   word;
    logic [LB-1:0]   cnt_inc;
    logic [LB-1:0]   need;
    logic            hdr_phase;
    logic            field_done;
    logic            pay_done;
    logic            magic_ok;
    logic            ver_ok;
    logic            len_ok;
    logic            crc_ok;
    rdc_pkg::t_job   job;

    // field decode
    always_comb begin
        eof        = i_item.end_of_file;
        first      = (r_phase == rdc_pkg::PH_MAGIC) && (r_count == '0);
        cur_start  = first ? r_pos : r_start;
        cur_len    = first ? '0 : r_len;
        word       = r_shift | (WW'(i_item.data_byte) << {r_count[1:0], 3'b000});
        cnt_inc    = r_count + 1'b1;
        need       = (r_phase == rdc_pkg::PH_VERSION) ? LB'(rdc_pkg::VERSION_BYTES)
                                                      : LB'(rdc_pkg::WORD_BYTES);
        hdr_phase  = (r_phase == rdc_pkg::PH_MAGIC) || (r_phase == rdc_pkg::PH_VERSION) ||
                     (r_phase == rdc_pkg::PH_LENGTH) || (r_phase == rdc_pkg::PH_CRC);
        field_done = hdr_phase && (cnt_inc >= need);
        pay_done   = cnt_inc >= r_len;
        magic_ok   = word == r_magic;
        ver_ok     = word[rdc_pkg::VERSION_W-1:0] == r_version;
        len_ok     = (word != '0) && (word <= WW'(r_max)) && ((word >> LB) == '0);
        crc_ok     = ~r_crc == word;
    end

    // next parse phase and halt
    always_comb begin
        phase_step = r_phase;
        halt_step  = r_halted;
        if (!r_halted) begin
            case (r_phase)
                rdc_pkg::PH_MAGIC: begin
                    if (field_done) begin
                        if (magic_ok) phase_step = rdc_pkg::PH_VERSION;
                        else          halt_step  = 1'b1;
                    end
                end
                rdc_pkg::PH_VERSION: begin
                    if (field_done) begin
                        if (ver_ok) phase_step = rdc_pkg::PH_LENGTH;
                        else        halt_step  = 1'b1;
                    end
                end
                rdc_pkg::PH_LENGTH: begin
                    if (field_done) begin
                        if (len_ok) phase_step = rdc_pkg::PH_PAYLOAD;
                        else        halt_step  = 1'b1;
                    end
                end
                rdc_pkg::PH_PAYLOAD: begin
                    if (pay_done) phase_step = rdc_pkg::PH_CRC;
                end
                rdc_pkg::PH_CRC: begin
                    if (field_done) begin
                        phase_step = rdc_pkg::PH_MAGIC;
                        if (!crc_ok) halt_step = 1'b1;
                    end
                end
                default: phase_step = rdc_pkg::PH_MAGIC;
            endcase
        end

        n_phase  = r_phase;
        n_halted = r_halted;
        if (i_accept) begin
            n_phase  = eof ? rdc_pkg::PH_MAGIC : phase_step;
            n_halted = eof ? 1'b0 : halt_step;
        end
    end

    // datapath and results
    always_comb begin
        count_step = r_count;
        shift_step = r_shift;
        crc_step   = r_crc;
        len_step   = r_halted ? r_len : cur_len;
        start_step = r_halted ? r_start : cur_start;
        job        = '0;
        job.offset = rdc_pkg::OFFSET_W'(cur_start);
        job.length = rdc_pkg::PLEN_W'(cur_len);

        if (!r_halted) begin
            case (r_phase)
                rdc_pkg::PH_MAGIC, rdc_pkg::PH_VERSION, rdc_pkg::PH_LENGTH,
                rdc_pkg::PH_CRC: begin
                    if (field_done) begin
                        count_step = '0;
                        shift_step = '0;
                    end else begin
                        count_step = cnt_inc;
                        shift_step = word;
                    end
                    if (field_done) begin
                        if (r_phase == rdc_pkg::PH_MAGIC && !magic_ok) begin
                            job.has_stat = 1'b1;
                            job.status   = rdc_pkg::ST_BAD_MAGIC;
                            job.length   = '0;
                        end
                        if (r_phase == rdc_pkg::PH_VERSION && !ver_ok) begin
                            job.has_stat = 1'b1;
                            job.status   = rdc_pkg::ST_BAD_VERSION;
                            job.length   = '0;
                        end
                        if (r_phase == rdc_pkg::PH_LENGTH) begin
                            if (len_ok) begin
                                len_step = LB'(word);
                                crc_step = '1;
                            end else begin
                                job.has_stat = 1'b1;
                                job.status   = rdc_pkg::ST_BAD_LENGTH;
                                job.length   = rdc_pkg::PLEN_W'(word);
                            end
                        end
                        if (r_phase == rdc_pkg::PH_CRC) begin
                            job.has_stat = 1'b1;
                            job.status   = crc_ok ? rdc_pkg::ST_OK : rdc_pkg::ST_CRC_MISMATCH;
                        end
                    end
                end
                rdc_pkg::PH_PAYLOAD: begin
                    job.has_pay  = 1'b1;
                    job.pay_byte = i_item.data_byte;
                    crc_step     = rdc_pkg::crc32_byte(r_crc, i_item.data_byte);
                    if (pay_done) begin
                        count_step = '0;
                        shift_step = '0;
                    end else begin
                        count_step = cnt_inc;
                    end
                end
                default: begin
                    count_step = '0;
                    shift_step = '0;
                end
            endcase

            // record cut short by end of file
            if (eof && !halt_step) begin
                if (phase_step == rdc_pkg::PH_PAYLOAD) begin
                    job.has_stat = 1'b1;
                    job.status   = rdc_pkg::ST_SHORT_PAYLOAD;
                    job.length   = rdc_pkg::PLEN_W'(len_step);
                end else if (phase_step == rdc_pkg::PH_CRC) begin
                    job.has_stat = 1'b1;
                    job.status   = rdc_pkg::ST_MISSING_CRC;
                    job.length   = rdc_pkg::PLEN_W'(len_step);
                end else if (phase_step == rdc_pkg::PH_VERSION ||
                             phase_step == rdc_pkg::PH_LENGTH ||
                             (phase_step == rdc_pkg::PH_MAGIC && count_step != '0)) begin
                    job.has_stat = 1'b1;
                    job.status   = rdc_pkg::ST_SHORT_HDR;
                    job.length   = '0;
                end
            end
        end

        n_count = r_count;
        n_shift = r_shift;
        n_crc   = r_crc;
        n_len   = r_len;
        n_start = r_start;
        n_pos   = r_pos;
        if (i_accept) begin
            if (eof) begin
                n_count = '0;
                n_shift = '0;
                n_crc   = '1;
                n_len   = '0;
                n_start = '0;
                n_pos   = '0;
            end else begin
                n_count = count_step;
                n_shift = shift_step;
                n_crc   = crc_step;
                n_len   = len_step;
                n_start = start_step;
                n_pos   = r_pos + 1'b1;
            end
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.has_pay || job.has_stat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= rdc_pkg::MAGIC_RESET;
            r_version <= rdc_pkg::VERSION_RESET;
            r_max     <= rdc_pkg::MAXLEN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rdc_pkg::CFG_MAGIC:   r_magic   <= i_cfg_wdata[WW-1:0];
                rdc_pkg::CFG_VERSION: r_version <= i_cfg_wdata[rdc_pkg::VERSION_W-1:0];
                rdc_pkg::CFG_MAXLEN:  r_max     <= i_cfg_wdata[rdc_pkg::MAXLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rdc_pkg::PH_MAGIC;
            r_halted <= 1'b0;
            r_count  <= '0;
            r_shift  <= '0;
            r_crc    <= '1;
            r_len    <= '0;
            r_pos    <= '0;
            r_start  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_halted <= n_halted;
            r_count  <= n_count;
            r_shift  <= n_shift;
            r_crc    <= n_crc;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_start  <= n_start;
        end
    end

    `ASSERT_IMPLY(a_halted_silent, r_halted, !o_push, "result produced while halted")
    `ASSERT_IMPLY(a_pair_is_truncation, o_push && o_job.has_pay && o_job.has_stat,
        o_job.status == rdc_pkg::ST_SHORT_PAYLOAD || o_job.status == rdc_pkg::ST_MISSING_CRC,
        "payload paired with a status other than a truncation")

endmodule

FILE: rtl/core/rdc_queue.sv
// short result queue between parser and output stage
module rdc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rdc_pkg::t_job     i_job,
    input  logic              i_pop,
    output rdc_pkg::t_job     o_head,
    output rdc_pkg::t_q_flags o_flags
);

    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(rdc_pkg::Q_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rdc_pkg::Q_DEPTH);

    rdc_pkg::t_job    r_mem [rdc_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_flags.full  = r_count == FULL_CNT;
    assign o_flags.empty = r_count == '0;
    assign do_push       = i_push && !o_flags.full;
    assign do_pop        = i_pop && !o_flags.empty;
    assign o_head        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, !(i_push && r_count == FULL_CNT), "push into full queue")
    `ASSERT_NEXT(a_fill_tracks, i_push && !i_pop, r_count == $past(r_count) + 1'b1,
        "queue fill did not follow a lone push")

endmodule

FILE: rtl/core/rdc_back.sv
// output stage: unpacks queue entries into result transactions
module rdc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdc_pkg::t_job      i_head,
    input  rdc_pkg::t_q_flags  i_flags,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output rdc_pkg::t_out_item o_item
);

    `include "assert_macros.svh"

    logic               r_valid, n_valid;
    logic               r_pend, n_pend;
    rdc_pkg::t_out_item r_item, n_item;
    rdc_pkg::t_out_item r_pend_item, n_pend_item;
    rdc_pkg::t_out_item pay_item;
    rdc_pkg::t_out_item stat_item;
    logic               load;

    always_comb begin
        pay_item               = '0;
        pay_item.item_kind     = rdc_pkg::KIND_PAYLOAD;
        pay_item.payload_byte  = i_head.pay_byte;
        pay_item.record_offset = i_head.offset;
        pay_item.rec_length    = i_head.length;
        pay_item.last          = !i_head.has_stat;

        stat_item               = '0;
        stat_item.item_kind     = rdc_pkg::KIND_STATUS;
        stat_item.status        = i_head.status;
        stat_item.record_offset = i_head.offset;
        stat_item.rec_length    = i_head.length;
        stat_item.last          = 1'b1;
    end

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !r_pend && !i_flags.empty;

    always_comb begin
        n_valid     = r_valid;
        n_pend      = r_pend;
        n_item      = r_item;
        n_pend_item = r_pend_item;
        if (load) begin
            if (r_pend) begin
                n_valid = 1'b1;
                n_item  = r_pend_item;
                n_pend  = 1'b0;
            end else if (!i_flags.empty) begin
                n_valid = 1'b1;
                if (i_head.has_pay) begin
                    n_item      = pay_item;
                    n_pend      = i_head.has_stat;
                    n_pend_item = stat_item;
                end else begin
                    n_item = stat_item;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_pend_item <= n_pend_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    `ASSERT_IMPLY(a_pend_behind_payload, r_pend,
        r_valid && r_item.item_kind == rdc_pkg::KIND_PAYLOAD && !r_item.last,
        "pending status without a payload transaction ahead of it")

endmodule

FILE: test/record_deframer_crc_check_tb.sv
// self-checking testbench of the record deframer: byte files in, payload and status checked
module record_deframer_crc_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_BYTES = 250;
    localparam int SETTLE_CYCLES = 4;   // extra wait once all bytes are in and all results are out
    // index with no register behind it
    localparam logic [rdc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // defects that the stimulus can plant in one record
    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_LENGTH_ZERO,
        FLAW_LENGTH_BIG,
        FLAW_CRC
    } t_flaw;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    rdc_pkg::t_in_item              in_item = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    rdc_pkg::t_out_item             out_item;
    logic                           cfg_wr_en = 1'b0;
    logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    record_deframer_crc_check dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // register copies, kept in step with every write
    logic [31:0] want_magic   = rdc_pkg::MAGIC_RESET;
    logic [15:0] want_version = rdc_pkg::VERSION_RESET;
    logic [19:0] want_maxlen  = rdc_pkg::MAXLEN_RESET;

    // parser state of the prediction
    rdc_pkg::t_phase ph;
    logic [19:0]     fcount;
    logic [31:0]     fshift;
    logic [31:0]     crc_run;
    logic [19:0]     len_held;
    logic [31:0]     byte_pos;
    logic [31:0]     rec_start;
    bit              halted_now;

    rdc_pkg::t_in_item  bytes_to_send[$];   // file bytes waiting for the driver
    rdc_pkg::t_out_item results_due[$];     // predicted results, oldest first
    logic [7:0]         file_buf[$];        // file under construction

    int failures = 0;
    int cycle_count = 0;
    int sent_bytes = 0;
    int files_sent = 0;
    int settings_used = 1;
    int payload_seen = 0;
    int status_seen[8];

    // handshake bookkeeping between the edges
    bit in_took = 1'b0;
    bit out_took = 1'b0;
    int in_gap = 0;
    int out_wait = 0;
    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // reflected crc-32, data bits fed in one per shift
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (rdc_pkg::CRC_POLY & {32{r[0] ^ b[k]}});
        end
        return r;
    endfunction

    // back to the start of a file, registers untouched
    task automatic clear_parse();
        ph         = rdc_pkg::PH_MAGIC;
        fcount     = '0;
        fshift     = '0;
        crc_run    = '1;
        len_held   = '0;
        byte_pos   = '0;
        rec_start  = '0;
        halted_now = 1'b0;
    endtask

    function automatic rdc_pkg::t_out_item report(input logic kind, input logic [7:0] pb,
                                                  input rdc_pkg::t_status st,
                                                  input logic [19:0] len);
        rdc_pkg::t_out_item r;
        r.item_kind     = kind;
        r.payload_byte  = pb;
        r.status        = st;
        r.record_offset = rec_start;
        r.rec_length    = len;
        r.last          = 1'b0;
        return r;
    endfunction

    // parse one file byte and queue what it must produce
    task automatic deframe_byte(input rdc_pkg::t_in_item it);
        rdc_pkg::t_out_item made[$];
        logic [31:0] word;
        int need;
        if (!halted_now) begin
            // first magic byte opens a record
            if (ph == rdc_pkg::PH_MAGIC && fcount == 0) begin
                rec_start = byte_pos;
                len_held  = '0;
            end
            if (ph == rdc_pkg::PH_PAYLOAD) begin
                made.insert(made.size(), report(rdc_pkg::KIND_PAYLOAD, it.data_byte,
                                                rdc_pkg::ST_OK, len_held));
                crc_run = crc_step(crc_run, it.data_byte);
                fcount++;
                if (fcount >= len_held) begin
                    fcount = '0;
                    fshift = '0;
                    ph     = rdc_pkg::PH_CRC;
                end
            end else begin
                // little-endian header and trailer fields
                need = (ph == rdc_pkg::PH_VERSION) ? rdc_pkg::VERSION_BYTES
                                                   : rdc_pkg::WORD_BYTES;
                fshift |= 32'(it.data_byte) << (8 * fcount[1:0]);
                fcount++;
                if (fcount >= need) begin
                    word   = fshift;
                    fcount = '0;
                    fshift = '0;
                    case (ph)
                        rdc_pkg::PH_MAGIC: begin
                            if (word != want_magic) begin
                                made.insert(made.size(),
                                            report(rdc_pkg::KIND_STATUS, 8'd0,
                                                   rdc_pkg::ST_BAD_MAGIC, 20'd0));
                                halted_now = 1'b1;
                            end else begin
                                ph = rdc_pkg::PH_VERSION;
                            end
                        end
                        rdc_pkg::PH_VERSION: begin
                            if (word[15:0] != want_version) begin
                                made.insert(made.size(),
                                            report(rdc_pkg::KIND_STATUS, 8'd0,
                                                   rdc_pkg::ST_BAD_VERSION, 20'd0));
                                halted_now = 1'b1;
                            end else begin
                                ph = rdc_pkg::PH_LENGTH;
                            end
                        end
                        rdc_pkg::PH_LENGTH: begin
                            // zero, over the limit, or wider than the length field
                            if (word == 0 || word > 32'(want_maxlen) ||
                                (word >> rdc_pkg::LENGTH_BITS) != 0) begin
                                made.insert(made.size(),
                                            report(rdc_pkg::KIND_STATUS, 8'd0,
                                                   rdc_pkg::ST_BAD_LENGTH, word[19:0]));
                                halted_now = 1'b1;
                            end else begin
                                len_held = word[19:0];
                                crc_run  = '1;
                                ph       = rdc_pkg::PH_PAYLOAD;
                            end
                        end
                        default: begin
                            // trailer holds the inverted crc of the payload
                            made.insert(made.size(),
                                        report(rdc_pkg::KIND_STATUS, 8'd0,
                                               (~crc_run == word) ? rdc_pkg::ST_OK
                                                                  : rdc_pkg::ST_CRC_MISMATCH,
                                               len_held));
                            if (~crc_run != word) halted_now = 1'b1;
                            ph = rdc_pkg::PH_MAGIC;
                        end
                    endcase
                end
            end

            // file cut short inside a record
            if (it.end_of_file && !halted_now) begin
                if (ph == rdc_pkg::PH_PAYLOAD) begin
                    made.insert(made.size(), report(rdc_pkg::KIND_STATUS, 8'd0,
                                                    rdc_pkg::ST_SHORT_PAYLOAD, len_held));
                end else if (ph == rdc_pkg::PH_CRC) begin
                    made.insert(made.size(), report(rdc_pkg::KIND_STATUS, 8'd0,
                                                    rdc_pkg::ST_MISSING_CRC, len_held));
                end else if (ph != rdc_pkg::PH_MAGIC || fcount != 0) begin
                    made.insert(made.size(), report(rdc_pkg::KIND_STATUS, 8'd0,
                                                    rdc_pkg::ST_SHORT_HDR, 20'd0));
                end
            end
        end

        byte_pos++;
        if (it.end_of_file) clear_parse();
        if (made.size() > 0) made[made.size() - 1].last = 1'b1;
        foreach (made[i]) results_due.insert(results_due.size(), made[i]);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------

    task automatic append_le(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++) file_buf.insert(file_buf.size(), value[8*i +: 8]);
    endtask

    task automatic append_header(input logic [31:0] magic, input logic [15:0] version,
                                 input logic [31:0] len);
        append_le(magic, rdc_pkg::WORD_BYTES);
        append_le(32'(version), rdc_pkg::VERSION_BYTES);
        append_le(len, rdc_pkg::WORD_BYTES);
    endtask

    // one record under the current settings; plen 0 picks a small random length
    task automatic append_record(input t_flaw flaw, input int plen);
        logic [31:0] magic;
        logic [15:0] version;
        logic [31:0] len;
        logic [31:0] crc;
        logic [7:0]  b;
        magic   = want_magic;
        version = want_version;
        if (plen == 0) plen = $urandom_range(1, (want_maxlen < 12) ? int'(want_maxlen) : 12);
        len = plen;
        case (flaw)
            FLAW_MAGIC:       magic ^= 32'd1 << $urandom_range(0, 31);
            FLAW_VERSION:     version ^= 16'd1 << $urandom_range(0, 15);
            FLAW_LENGTH_ZERO: len = '0;
            FLAW_LENGTH_BIG: begin
                // just over the limit, or beyond the length field
                if ($urandom_range(0, 1) == 1) len = 32'(want_maxlen) + 32'($urandom_range(1, 4));
                else len = $urandom | 32'h0010_0000;
            end
            default: ;
        endcase
        append_header(magic, version, len);
        if (flaw == FLAW_NONE || flaw == FLAW_CRC) begin
            crc = '1;
            repeat (plen) begin
                b = 8'($urandom);
                file_buf.insert(file_buf.size(), b);
                crc = crc_step(crc, b);
            end
            crc = ~crc;
            if (flaw == FLAW_CRC) crc ^= 32'd1 << $urandom_range(0, 31);
            append_le(crc, rdc_pkg::WORD_BYTES);
        end else begin
            // the parser has stopped, these bytes must be ignored
            repeat ($urandom_range(0, 6)) file_buf.insert(file_buf.size(), 8'($urandom));
        end
    endtask

    // hand the file to the driver, keeping only the first keep bytes if keep is set
    task automatic send_file(input int keep);
        rdc_pkg::t_in_item it;
        if (keep <= 0 || keep > file_buf.size()) keep = file_buf.size();
        for (int i = 0; i < keep; i++) begin
            it.data_byte   = file_buf[i];
            it.end_of_file = (i == keep - 1);
            bytes_to_send.insert(bytes_to_send.size(), it);
        end
        sent_bytes += keep;
        files_sent++;
        file_buf.delete();
    endtask

    // mostly well-formed record files, some with a planted defect or a cut, some noise
    task automatic random_file();
        int nrec;
        t_flaw flaw;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) file_buf.insert(file_buf.size(), 8'($urandom));
        end else begin
            nrec = $urandom_range(1, 4);
            repeat (nrec) begin
                flaw = ($urandom_range(0, 5) == 0) ? t_flaw'($urandom_range(1, 5)) : FLAW_NONE;
                append_record(flaw, 0);
            end
        end
        send_file(($urandom_range(0, 4) == 0) ? $urandom_range(1, file_buf.size()) : 0);
    endtask

    // ------------------------------------------------------------------
    // register writes, only while the block is idle
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [rdc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            rdc_pkg::CFG_MAGIC:   want_magic   = value;
            rdc_pkg::CFG_VERSION: want_version = value[15:0];
            rdc_pkg::CFG_MAXLEN:  want_maxlen  = value[19:0];
            default: ;
        endcase
    endtask

    // unused upper data bits carry noise, the block must drop them
    task automatic configure(input logic [31:0] magic, input logic [15:0] version,
                             input logic [19:0] maxlen);
        write_reg(rdc_pkg::CFG_MAGIC, magic);
        write_reg(rdc_pkg::CFG_VERSION, {16'($urandom), version});
        write_reg(rdc_pkg::CFG_MAXLEN, {12'($urandom), maxlen});
        @(negedge clk) cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // wait until every byte is in and every predicted result is out
    task automatic drain();
        while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // byte driver: changes inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            // a fresh gap after every accepted byte, with idle-free stretches
            if (in_took) begin
                if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;
                in_gap = in_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (in_valid && !in_took) begin
                // stalled transaction holds its byte
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
                in_item  <= bytes_to_send.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver stall: drawn after each accepted transaction
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_took) begin
                if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
                out_wait = out_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (out_wait > 0) begin
                out_wait--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: samples both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        rdc_pkg::t_out_item want;
        in_took  <= rst_n && in_valid && !in_stall;
        out_took <= rst_n && out_valid && !out_stall;

        // results first: a byte taken now cannot show up at this same edge
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                $error("result transaction with nothing expected: kind %0d status %0d",
                       out_item.item_kind, out_item.status);
                failures++;
            end else begin
                want = results_due.pop_front();
                check_field("item_kind", 32'(want.item_kind), 32'(out_item.item_kind));
                check_field("payload_byte", 32'(want.payload_byte), 32'(out_item.payload_byte));
                check_field("status", 32'(want.status), 32'(out_item.status));
                check_field("record_offset", want.record_offset, out_item.record_offset);
                check_field("rec_length", 32'(want.rec_length), 32'(out_item.rec_length));
                check_field("last", 32'(want.last), 32'(out_item.last));
            end
            if (out_item.item_kind == rdc_pkg::KIND_STATUS) status_seen[out_item.status]++;
            else payload_seen++;
        end

        if (rst_n && in_valid && !in_stall) deframe_byte(in_item);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run stopped at the cycle limit, %0d results still expected",
                   results_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int cuts[8];
        int target;
        cuts = '{1, 5, 9, 10, 12, 14, 16, 18};
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_parse();
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: reset settings, clean files
        append_record(FLAW_NONE, 1);
        send_file(0);
        append_record(FLAW_NONE, 3);
        append_record(FLAW_NONE, 0);
        send_file(0);

        // each header and trailer defect, with a good record after it that must be ignored
        for (int f = FLAW_MAGIC; f <= FLAW_CRC; f++) begin
            append_record(t_flaw'(f), 0);
            append_record(FLAW_NONE, 0);
            send_file(0);
        end

        // file cut in the magic, version, length, before and inside the payload,
        // before and inside the crc, and exactly at the record boundary
        foreach (cuts[i]) begin
            append_record(FLAW_NONE, 4);
            send_file(cuts[i]);
        end

        // widest length limit: one past the length field, all ones, largest small record
        drain();
        configure(want_magic, want_version, 20'hF_FFFF);
        append_header(want_magic, want_version, 32'h0010_0000);
        send_file(0);
        append_header(want_magic, want_version, 32'hFFFF_FFFF);
        send_file(0);
        append_record(FLAW_NONE, 12);
        send_file(0);

        // smallest limit with all-zero magic and version
        drain();
        configure(32'h0, 16'h0, 20'd1);
        append_record(FLAW_NONE, 1);
        append_record(FLAW_LENGTH_BIG, 0);
        send_file(0);

        // a write to the unused index leaves every register alone
        drain();
        write_reg(CFG_UNUSED, $urandom);
        @(negedge clk) cfg_wr_en <= 1'b0;
        append_record(FLAW_NONE, 1);
        append_record(FLAW_NONE, 0);
        send_file(0);

        // random files over several settings, the extremes among them
        for (int p = 0; p < 5; p++) begin
            drain();
            case (p)
                0: configure(rdc_pkg::MAGIC_RESET, rdc_pkg::VERSION_RESET,
                             rdc_pkg::MAXLEN_RESET);
                1: configure(32'h0, 16'h0, 20'd1);
                2: configure(32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF);
                3: configure($urandom, 16'($urandom), 20'($urandom_range(1, 24)));
                default: configure($urandom, 16'($urandom), 20'($urandom_range(1, 20'hF_FFFF)));
            endcase
            target = sent_bytes + RANDOM_BYTES / 5;
            while (sent_bytes < target) random_file();
        end

        drain();
        repeat (8) @(posedge clk);
        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            failures++;
        end

        $display("covered %0d bytes, %0d files, %0d register settings, %0d payload bytes out",
                 sent_bytes, files_sent, settings_used, payload_seen);
        $display("record reports, ok to crc mismatch: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[rdc_pkg::ST_OK], status_seen[rdc_pkg::ST_SHORT_HDR],
                 status_seen[rdc_pkg::ST_BAD_MAGIC], status_seen[rdc_pkg::ST_BAD_VERSION],
                 status_seen[rdc_pkg::ST_BAD_LENGTH], status_seen[rdc_pkg::ST_SHORT_PAYLOAD],
                 status_seen[rdc_pkg::ST_MISSING_CRC], status_seen[rdc_pkg::ST_CRC_MISMATCH]);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rdc_pkg.sv
rtl/core/rdc_front.sv
rtl/core/rdc_queue.sv
rtl/core/rdc_back.sv
rtl/core/record_deframer_crc_check.sv
test/record_deframer_crc_check_tb.sv
